[src/mmp_pkg.sv]
// Shared types, codes and the control program of the modular matrix product core.
`default_nettype none

package mmp_pkg;

   localparam int SIZE_W     = 5;
   localparam int MOD_W      = 9;
   localparam int ACT_W      = 2;
   localparam int IDX_W      = 4;
   localparam int VAL_W      = 8;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
   localparam logic [MOD_W-1:0]  MOD_RESET  = 9'd2;
   localparam logic [MOD_W-1:0]  MOD_MIN    = 9'd1;
   localparam logic [MOD_W-1:0]  MOD_MAX    = 9'd256;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FETCH  = 3'd0;
   localparam step_type STEP_SETUP  = 3'd1;
   localparam step_type STEP_LOOP   = 3'd2;
   localparam step_type STEP_DRAIN1 = 3'd3;
   localparam step_type STEP_DRAIN2 = 3'd4;
   localparam step_type STEP_DIVI   = 3'd5;
   localparam step_type STEP_DIVS   = 3'd6;
   localparam step_type STEP_OUT    = 3'd7;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_READ_ACC,
      COND_IN_RANGE,
      COND_K_LAST,
      COND_DIV_LAST,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     ready;
      logic     acc_clear;
      logic     issue;
      logic     div_init;
      logic     div_step;
      logic     out_load;
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
   } ctrl_type;

   typedef struct packed {
      logic read_acc;
      logic in_range;
      logic k_last;
      logic div_last;
      logic out_free;
   } flags_type;

   // control store: one word per step
   function automatic ctrl_type microcode(input step_type step);
      ctrl_type w;
      w = '0;
      w.cond = COND_ALWAYS;
      case (step)
         STEP_FETCH: begin
            w.ready     = 1'b1;
            w.cond      = COND_READ_ACC;
            w.tgt_true  = STEP_SETUP;
            w.tgt_false = STEP_FETCH;
         end
         STEP_SETUP: begin
            w.acc_clear = 1'b1;
            w.cond      = COND_IN_RANGE;
            w.tgt_true  = STEP_LOOP;
            w.tgt_false = STEP_DIVI;
         end
         STEP_LOOP: begin
            w.issue     = 1'b1;
            w.cond      = COND_K_LAST;
            w.tgt_true  = STEP_DRAIN1;
            w.tgt_false = STEP_LOOP;
         end
         STEP_DRAIN1: begin
            w.tgt_true  = STEP_DRAIN2;
            w.tgt_false = STEP_DRAIN2;
         end
         STEP_DRAIN2: begin
            w.tgt_true  = STEP_DIVI;
            w.tgt_false = STEP_DIVI;
         end
         STEP_DIVI: begin
            w.div_init  = 1'b1;
            w.tgt_true  = STEP_DIVS;
            w.tgt_false = STEP_DIVS;
         end
         STEP_DIVS: begin
            w.div_step  = 1'b1;
            w.cond      = COND_DIV_LAST;
            w.tgt_true  = STEP_OUT;
            w.tgt_false = STEP_DIVS;
         end
         STEP_OUT: begin
            w.out_load  = 1'b1;
            w.cond      = COND_OUT_FREE;
            w.tgt_true  = STEP_FETCH;
            w.tgt_false = STEP_OUT;
         end
         default: begin
            w.tgt_true  = STEP_FETCH;
            w.tgt_false = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[src/mmp_if.sv]
// Request and response channel interfaces of the modular matrix product core.
`default_nettype none

interface mmp_req_if;
   logic                              valid;
   logic                              ready;
   logic [mmp_pkg::ACT_W-1:0]         action;
   logic [mmp_pkg::IDX_W-1:0]         row;
   logic [mmp_pkg::IDX_W-1:0]         col;
   logic [mmp_pkg::VAL_W-1:0]         value;

   modport source (output valid, action, row, col, value, input ready);
   modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface mmp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mmp_pkg::VAL_W-1:0]         product;

   modport source (output valid, product, input ready);
   modport sink   (input valid, product, output ready);
endinterface

`default_nettype wire

[src/mmp_sequencer.sv]
// Step counter and jump logic that walks the control store.
`default_nettype none

module mmp_sequencer (
   input  wire                 clock,
   input  wire                 reset,
   input  mmp_pkg::flags_type  flags,
   output mmp_pkg::ctrl_type   ctrl
);

   mmp_pkg::step_type step_ff;
   mmp_pkg::step_type step_in;
   logic              take;

   assign ctrl = mmp_pkg::microcode(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         mmp_pkg::COND_ALWAYS:   take = 1'b1;
         mmp_pkg::COND_READ_ACC: take = flags.read_acc;
         mmp_pkg::COND_IN_RANGE: take = flags.in_range;
         mmp_pkg::COND_K_LAST:   take = flags.k_last;
         mmp_pkg::COND_DIV_LAST: take = flags.div_last;
         mmp_pkg::COND_OUT_FREE: take = flags.out_free;
         default:                take = 1'b1;
      endcase
      step_in = take ? ctrl.tgt_true : ctrl.tgt_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mmp_pkg::STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

[src/mmp_datapath.sv]
// Matrix stores, multiply-accumulate pipe, bit-serial reducer and response register.
`default_nettype none

module mmp_datapath #(
   parameter int MAX_SIZE = 16
) (
   input  wire                             clock,
   input  wire                             reset,
   input  mmp_pkg::ctrl_type               ctrl,
   output mmp_pkg::flags_type              flags,
   input  wire [$clog2(MAX_SIZE+1)-1:0]    n_eff,
   input  wire [mmp_pkg::MOD_W-1:0]        q_eff,
   input  wire                             req_accept,
   input  wire                             req_valid,
   input  wire [mmp_pkg::ACT_W-1:0]        req_action,
   input  wire [mmp_pkg::IDX_W-1:0]        req_row,
   input  wire [mmp_pkg::IDX_W-1:0]        req_col,
   input  wire [mmp_pkg::VAL_W-1:0]        req_value,
   input  wire                             rsp_ready,
   output logic                            rsp_valid,
   output logic [mmp_pkg::VAL_W-1:0]       rsp_product
);

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(MAX_SIZE + 1);
   localparam int KW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int SW    = mmp_pkg::PROD_W + NW;
   localparam int DCW   = $clog2(SW);

   logic [mmp_pkg::VAL_W-1:0]  mem_a [DEPTH];
   logic [mmp_pkg::VAL_W-1:0]  mem_b [DEPTH];

   logic [mmp_pkg::IDX_W-1:0]  row_ff;
   logic [mmp_pkg::IDX_W-1:0]  col_ff;
   logic [KW-1:0]              k_ff;
   logic [mmp_pkg::VAL_W-1:0]  a_rd_ff;
   logic [mmp_pkg::VAL_W-1:0]  b_rd_ff;
   logic                       rd_vld_ff;
   logic [mmp_pkg::PROD_W-1:0] prod_ff;
   logic                       prod_vld_ff;
   logic [SW-1:0]              acc_ff;
   logic [mmp_pkg::VAL_W-1:0]  rem_ff;
   logic [mmp_pkg::VAL_W-1:0]  rem_in;
   logic [SW-1:0]              sh_ff;
   logic [DCW-1:0]             dcnt_ff;
   logic                       rsp_valid_ff;
   logic [mmp_pkg::VAL_W-1:0]  product_ff;

   logic                       wr_ok;
   logic                       wr_a;
   logic                       wr_b;
   logic [AW-1:0]              wr_addr;
   logic [AW-1:0]              rd_addr_a;
   logic [AW-1:0]              rd_addr_b;
   logic [mmp_pkg::MOD_W-1:0]  trial;
   logic                       out_free;

   assign wr_ok   = req_accept && (int'(req_row) < MAX_SIZE) && (int'(req_col) < MAX_SIZE);
   assign wr_a    = wr_ok && (req_action == mmp_pkg::ACT_WRITE_A);
   assign wr_b    = wr_ok && (req_action == mmp_pkg::ACT_WRITE_B);
   assign wr_addr = AW'(int'(req_row) * MAX_SIZE + int'(req_col));

   // A is walked down column row_ff, B along row col_ff
   assign rd_addr_a = AW'(int'(k_ff) * MAX_SIZE + int'(row_ff));
   assign rd_addr_b = AW'(int'(col_ff) * MAX_SIZE + int'(k_ff));

   // restoring reduction, one dividend bit per step
   assign trial  = {rem_ff, sh_ff[SW-1]};
   assign rem_in = (trial >= q_eff) ? mmp_pkg::VAL_W'(trial - q_eff)
                                    : mmp_pkg::VAL_W'(trial);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      flags.read_acc = req_valid && ctrl.ready && (req_action == mmp_pkg::ACT_READ);
      flags.in_range = (int'(row_ff) < int'(n_eff)) && (int'(col_ff) < int'(n_eff));
      flags.k_last   = (int'(k_ff) == int'(n_eff) - 1);
      flags.div_last = (dcnt_ff == DCW'(SW - 1));
      flags.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= req_value;
      end
      if (wr_b) begin
         mem_b[wr_addr] <= req_value;
      end
      a_rd_ff <= mem_a[rd_addr_a];
      b_rd_ff <= mem_b[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (ctrl.acc_clear) begin
         k_ff <= '0;
      end else if (ctrl.issue) begin
         k_ff <= k_ff + KW'(1);
      end
      prod_ff <= mmp_pkg::PROD_W'(a_rd_ff * b_rd_ff);
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + SW'(prod_ff);
      end
      if (ctrl.div_init) begin
         rem_ff  <= '0;
         sh_ff   <= acc_ff;
         dcnt_ff <= '0;
      end else if (ctrl.div_step) begin
         rem_ff  <= rem_in;
         sh_ff   <= sh_ff << 1;
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
      if (ctrl.out_load && out_free) begin
         product_ff <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ctrl.issue;
         prod_vld_ff <= rd_vld_ff;
         if (ctrl.out_load && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = product_ff;

endmodule

`default_nettype wire

[src/modular_matrix_product_core.sv]
// Top level of the modular matrix product core: CSRs, sequencer and datapath.
//
//   channel | dir | handshake    | payload
//   req_if  | in  | valid/ready  | action, row, col, value
//   rsp_if  | out | valid/ready  | product
//   csr     | in  | csr_we       | csr_index, csr_wdata
//
// Write requests are stored without leaving the fetch step. A read streams each k through
// the memory read ports and multiplier into an SW-bit sum, SW = 16 + clog2(MAX_SIZE+1)
// (21 at MAX_SIZE 16), then one bit per cycle through the bit-serial reducer. A read outside
// the size in use skips the k loop. Reset is synchronous and clears the sequencer,
// valid bits and CSRs; matrix stores are not cleared. A stalled response holds in its register
// while the next request is taken; a following read waits in its output step until it frees.
`default_nettype none

module modular_matrix_product_core #(
   parameter int MAX_SIZE = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   mmp_req_if.sink                            req_if,
   mmp_rsp_if.source                          rsp_if,
   input  wire                                csr_we,
   input  wire [mmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [mmp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NW = $clog2(MAX_SIZE + 1);

   logic [mmp_pkg::SIZE_W-1:0] size_ff;
   logic [mmp_pkg::MOD_W-1:0]  mod_ff;
   logic [NW-1:0]              n_eff;
   logic [mmp_pkg::MOD_W-1:0]  q_eff;
   mmp_pkg::ctrl_type          ctrl;
   mmp_pkg::flags_type         flags;
   logic                       req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mmp_pkg::SIZE_RESET;
         mod_ff  <= mmp_pkg::MOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mmp_pkg::CSR_SIZE:    size_ff <= csr_wdata[mmp_pkg::SIZE_W-1:0];
            mmp_pkg::CSR_MODULUS: mod_ff  <= csr_wdata[mmp_pkg::MOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff = (int'(size_ff) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_ff);
      priority if (mod_ff < mmp_pkg::MOD_MIN) begin
         q_eff = mmp_pkg::MOD_MIN;
      end else if (mod_ff > mmp_pkg::MOD_MAX) begin
         q_eff = mmp_pkg::MOD_MAX;
      end else begin
         q_eff = mod_ff;
      end
   end

   assign req_if.ready = ctrl.ready;
   assign req_accept   = req_if.valid && ctrl.ready;

   mmp_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   mmp_datapath #(
      .MAX_SIZE (MAX_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .flags       (flags),
      .n_eff       (n_eff),
      .q_eff       (q_eff),
      .req_accept  (req_accept),
      .req_valid   (req_if.valid),
      .req_action  (req_if.action),
      .req_row     (req_if.row),
      .req_col     (req_if.col),
      .req_value   (req_if.value),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_product (rsp_if.product)
   );

endmodule

`default_nettype wire

[src/mmp_checker.sv]
// Port-level assertions for the modular matrix product core, bound to the top level.
`default_nettype none

module mmp_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire [mmp_pkg::ACT_W-1:0]     req_action,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [mmp_pkg::VAL_W-1:0]     rsp_product
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // stalled response keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product))
      else $error("response changed while stalled");

   // out of reset: no response pending, ready for a request
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // a read request is followed by the setup step and then the loop or divide-init step, both not ready
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_action == mmp_pkg::ACT_READ |=> !req_ready ##1 !req_ready)
      else $error("request taken during a read");

   // write or unused request: back to ready, no response raised
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_action != mmp_pkg::ACT_READ |=> req_ready && !$rose(rsp_valid))
      else $error("write request stalled or answered");

endmodule

bind modular_matrix_product_core mmp_checker u_mmp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_action  (req_if.action),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_product (rsp_if.product)
);

`default_nettype wire
